### rtl/core/wcdg_pkg.sv
// ---------------------------------------------------------------------------
// wcdg_pkg
// Shared types and constants for the weighted chebyshev distance grad core
// ---------------------------------------------------------------------------
package wcdg_pkg;

    localparam int ELEM_W           = 16;
    localparam int DIST_W           = 32;
    localparam int GRAD_W           = 32;
    localparam int INDEX_W          = 10;
    localparam int MAX_FEATURES_DEF = 1024;

    // sign of left minus right
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd3;

    typedef struct packed {
        logic signed [ELEM_W-1:0] left_elem;
        logic signed [ELEM_W-1:0] right_elem;
        logic        [ELEM_W-1:0] weight_elem;
        logic signed [ELEM_W-1:0] upstream_grad;
        logic                     last_element;
    } in_word_t;

    typedef struct packed {
        logic        [DIST_W-1:0]  distance;
        logic        [INDEX_W-1:0] winner_index;
        logic signed [GRAD_W-1:0]  left_grad_part;
        logic signed [GRAD_W-1:0]  right_grad_part;
        logic signed [GRAD_W-1:0]  weight_grad_part;
    } out_word_t;

endpackage

### rtl/core/weighted_chebyshev_distance_grad_core.sv
// ---------------------------------------------------------------------------
// weighted_chebyshev_distance_grad_core
// Streaming weighted chebyshev distance with gradient parts per vector pair
// ---------------------------------------------------------------------------
// path: a last word enters the product register at acceptance, then moves to
//   the gradient stage, then to the output register where its result is valid
// throughput: one input word per cycle while no last word waits on a busy
//   gradient stage; set by the compare/update loop on the best-value registers
// reset: synchronous active-low aresetn clears all valid flags, the element
//   counter and min_mode; the pair in flight is dropped
module weighted_chebyshev_distance_grad_core #(
    parameter int MAX_FEATURES = wcdg_pkg::MAX_FEATURES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write channel (min_mode)
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_wdata,
    // feature element words
    input  logic                s_valid,
    output logic                s_ready,
    input  wcdg_pkg::in_word_t  s_data,
    // result words, one per vector pair
    output logic                m_valid,
    input  logic                m_ready,
    output wcdg_pkg::out_word_t m_data
);

    localparam int EW    = wcdg_pkg::ELEM_W;
    localparam int DW    = wcdg_pkg::DIST_W;
    localparam int GW    = wcdg_pkg::GRAD_W;
    localparam int IW    = wcdg_pkg::INDEX_W;
    // element counter holds indexes 0 .. MAX_FEATURES-1
    localparam int CNT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int POS_X = (CNT_W > IW) ? CNT_W : IW;
    localparam logic [CNT_W-1:0] MAX_IDX = CNT_W'(MAX_FEATURES - 1);

    // product stage word
    typedef struct packed {
        logic        [DW-1:0] weighted;
        logic        [EW-1:0] abs_diff;
        logic        [1:0]    sgn;
        logic        [EW-1:0] weight;
        logic signed [EW-1:0] grad;
        logic                 last;
    } prod_t;

    // config register
    logic min_mode_reg, min_mode_next;

    // input side: difference, magnitude, sign and weighted product
    logic signed [EW:0]   diff;
    logic        [EW:0]   diff_mag;
    prod_t                prod_in;

    // product stage
    prod_t prod_reg;
    logic  prod_valid_reg, prod_valid_next;

    // running best of the current pair
    logic [DW-1:0]    best_weighted_reg, best_weighted_next;
    logic [EW-1:0]    best_abs_diff_reg, best_abs_diff_next;
    logic [1:0]       best_sign_reg, best_sign_next;
    logic [EW-1:0]    best_weight_reg, best_weight_next;
    logic [CNT_W-1:0] best_pos_reg, best_pos_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // gradient stage, holds the winner of a finished pair
    logic                 grad_valid_reg, grad_valid_next;
    logic [DW-1:0]        fin_dist_reg, fin_dist_next;
    logic [CNT_W-1:0]     fin_pos_reg, fin_pos_next;
    logic [EW-1:0]        fin_abs_reg, fin_abs_next;
    logic [1:0]           fin_sign_reg, fin_sign_next;
    logic [EW-1:0]        fin_weight_reg, fin_weight_next;
    logic signed [EW-1:0] fin_grad_reg, fin_grad_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    wcdg_pkg::out_word_t  out_reg, out_next;

    // selection and flow control
    logic             first_elem;
    logic             better;
    logic             take;
    logic [DW-1:0]    sel_weighted;
    logic [EW-1:0]    sel_abs_diff;
    logic [1:0]       sel_sign;
    logic [EW-1:0]    sel_weight;
    logic [CNT_W-1:0] sel_pos;
    logic             out_free;
    logic             grad_free;
    logic             prod_fire;
    logic             s_fire;
    logic             grad_move;

    // gradient products
    logic signed [EW+EW:0] gw_prod;
    logic signed [EW+EW:0] lg_prod;
    logic signed [EW+EW:0] wg_prod;
    logic [POS_X-1:0]      pos_ext;

    // ------------------------------------------------------------------
    // handshakes: a word leaves the product stage every cycle unless it is
    // a last word and the gradient stage cannot take the finished pair
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign grad_free = !grad_valid_reg || out_free;
    assign prod_fire = prod_valid_reg && (!prod_reg.last || grad_free);
    assign s_ready   = !prod_valid_reg || prod_fire;
    assign s_fire    = s_valid && s_ready;
    assign grad_move = grad_valid_reg && out_free;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ------------------------------------------------------------------
    // input side: 17-bit difference, magnitude fits 16 bits (max 65535)
    // ------------------------------------------------------------------
    always_comb begin
        diff     = {s_data.left_elem[EW-1], s_data.left_elem}
                 - {s_data.right_elem[EW-1], s_data.right_elem};
        diff_mag = diff[EW] ? (EW+1)'(-diff) : diff;

        prod_in.abs_diff = diff_mag[EW-1:0];
        if (diff[EW]) begin
            prod_in.sgn = wcdg_pkg::SIGN_NEG;
        end else if (diff != '0) begin
            prod_in.sgn = wcdg_pkg::SIGN_POS;
        end else begin
            prod_in.sgn = wcdg_pkg::SIGN_ZERO;
        end
        prod_in.weighted = DW'(diff_mag[EW-1:0]) * DW'(s_data.weight_elem);
        prod_in.weight   = s_data.weight_elem;
        prod_in.grad     = s_data.upstream_grad;
        prod_in.last     = s_data.last_element;
    end

    // ------------------------------------------------------------------
    // compare against the running best; first element of a pair seeds it,
    // ties keep the earlier element
    // ------------------------------------------------------------------
    always_comb begin
        first_elem = (count_reg == '0);
        if (min_mode_reg) begin
            better = prod_reg.weighted < best_weighted_reg;
        end else begin
            better = prod_reg.weighted > best_weighted_reg;
        end
        take = first_elem || better;

        sel_weighted = take ? prod_reg.weighted : best_weighted_reg;
        sel_abs_diff = take ? prod_reg.abs_diff : best_abs_diff_reg;
        sel_sign     = take ? prod_reg.sgn      : best_sign_reg;
        sel_weight   = take ? prod_reg.weight   : best_weight_reg;
        sel_pos      = take ? count_reg         : best_pos_reg;
    end

    // ------------------------------------------------------------------
    // next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        min_mode_next = min_mode_reg;
        if (cfg_valid && cfg_ready) begin
            min_mode_next = cfg_wdata;
        end

        // product stage
        prod_valid_next = prod_valid_reg;
        if (s_fire) begin
            prod_valid_next = 1'b1;
        end else if (prod_fire) begin
            prod_valid_next = 1'b0;
        end

        // running best and element counter
        best_weighted_next = best_weighted_reg;
        best_abs_diff_next = best_abs_diff_reg;
        best_sign_next     = best_sign_reg;
        best_weight_next   = best_weight_reg;
        best_pos_next      = best_pos_reg;
        count_next         = count_reg;
        if (prod_fire) begin
            if (prod_reg.last) begin
                // pair done, next word starts a new pair
                count_next = '0;
            end else begin
                best_weighted_next = sel_weighted;
                best_abs_diff_next = sel_abs_diff;
                best_sign_next     = sel_sign;
                best_weight_next   = sel_weight;
                best_pos_next      = sel_pos;
                // index saturates at the top feature
                if (count_reg != MAX_IDX) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end

        // gradient stage
        grad_valid_next = grad_valid_reg;
        fin_dist_next   = fin_dist_reg;
        fin_pos_next    = fin_pos_reg;
        fin_abs_next    = fin_abs_reg;
        fin_sign_next   = fin_sign_reg;
        fin_weight_next = fin_weight_reg;
        fin_grad_next   = fin_grad_reg;
        if (prod_fire && prod_reg.last) begin
            grad_valid_next = 1'b1;
            fin_dist_next   = sel_weighted;
            fin_pos_next    = sel_pos;
            fin_abs_next    = sel_abs_diff;
            fin_sign_next   = sel_sign;
            fin_weight_next = sel_weight;
            fin_grad_next   = prod_reg.grad;
        end else if (grad_move) begin
            grad_valid_next = 1'b0;
        end

        // gradient products, exact in 33 bits, low 32 bits kept
        gw_prod = (EW+EW+1)'(fin_grad_reg) * (EW+EW+1)'($signed({1'b0, fin_weight_reg}));
        wg_prod = (EW+EW+1)'(fin_grad_reg) * (EW+EW+1)'($signed({1'b0, fin_abs_reg}));
        case (fin_sign_reg)
            wcdg_pkg::SIGN_POS: lg_prod = gw_prod;
            wcdg_pkg::SIGN_NEG: lg_prod = -gw_prod;
            default:            lg_prod = '0;
        endcase
        pos_ext = POS_X'(fin_pos_reg);

        // output register
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (grad_move) begin
            out_valid_next            = 1'b1;
            out_next.distance         = fin_dist_reg;
            out_next.winner_index     = pos_ext[IW-1:0];
            out_next.left_grad_part   = lg_prod[GW-1:0];
            out_next.right_grad_part  = GW'(-lg_prod);
            out_next.weight_grad_part = wg_prod[GW-1:0];
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_mode_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            count_reg      <= '0;
            grad_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            min_mode_reg   <= min_mode_next;
            prod_valid_reg <= prod_valid_next;
            count_reg      <= count_next;
            grad_valid_reg <= grad_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // payload registers, no reset needed (seeded by the first element)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            prod_reg <= prod_in;
        end
        best_weighted_reg <= best_weighted_next;
        best_abs_diff_reg <= best_abs_diff_next;
        best_sign_reg     <= best_sign_next;
        best_weight_reg   <= best_weight_next;
        best_pos_reg      <= best_pos_next;
        fin_dist_reg      <= fin_dist_next;
        fin_pos_reg       <= fin_pos_next;
        fin_abs_reg       <= fin_abs_next;
        fin_sign_reg      <= fin_sign_next;
        fin_weight_reg    <= fin_weight_next;
        fin_grad_reg      <= fin_grad_next;
        out_reg           <= out_next;
    end

`ifndef SYNTHESIS
    // counter never passes the top feature index
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_IDX)
        else $error("element counter beyond top index");

    // a finished pair restarts the counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        prod_fire && prod_reg.last |=> count_reg == '0)
        else $error("counter not cleared after last element");

    // an accepted word always lands in the product stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> prod_valid_reg)
        else $error("accepted word lost");

    // a result only appears from a held gradient stage entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(grad_valid_reg))
        else $error("result without finished pair");
`endif

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted chebyshev distance grad core: streams
// vector pairs word by word, predicts each pair's result word and compares
// every field against the result channel
// ---------------------------------------------------------------------------
module tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TOP_INDEX    = wcdg_pkg::MAX_FEATURES_DEF - 1;
    localparam int RANDOM_ITEMS = 280;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_wdata = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    wcdg_pkg::in_word_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    wcdg_pkg::out_word_t m_data;

    // running best values of the pair in flight, as the core should hold them
    logic        model_min_mode = 1'b0;
    logic [31:0] run_weighted   = '0;
    logic [15:0] run_abs_diff   = '0;
    logic [1:0]  run_sign       = wcdg_pkg::SIGN_ZERO;
    logic [15:0] run_weight     = '0;
    int          run_position   = 0;
    int          run_count      = 0;

    wcdg_pkg::out_word_t pending_results[$];
    int        error_count = 0;
    int        burst_left  = 0;
    int        idle_cycles = 0;
    int        stall_mode  = 0;
    int        stall_left  = 0;

    weighted_chebyshev_distance_grad_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // fold one accepted element word into the running best values
    task automatic track_element(input wcdg_pkg::in_word_t w);
        int          diff;
        logic [15:0] abs_diff;
        logic [1:0]  sgn;
        logic [31:0] weighted;
        logic        take;
        longint      grad_w;
        longint      left_g;
        longint      right_g;
        longint      weight_g;
        wcdg_pkg::out_word_t r;
        diff     = int'(w.left_elem) - int'(w.right_elem);
        abs_diff = (diff < 0) ? 16'(-diff) : 16'(diff);
        sgn      = (diff > 0) ? wcdg_pkg::SIGN_POS :
                   ((diff < 0) ? wcdg_pkg::SIGN_NEG : wcdg_pkg::SIGN_ZERO);
        weighted = 32'(abs_diff) * 32'(w.weight_elem);
        if (run_count == 0) begin
            take = 1'b1;
        end else if (model_min_mode) begin
            take = weighted < run_weighted;
        end else begin
            take = weighted > run_weighted;
        end
        if (take) begin
            run_weighted = weighted;
            run_abs_diff = abs_diff;
            run_sign     = sgn;
            run_weight   = w.weight_elem;
            run_position = run_count;
        end
        // index saturates at the top feature
        if (run_count < TOP_INDEX) run_count++;
        if (w.last_element) begin
            grad_w   = longint'(w.upstream_grad) * longint'(run_weight);
            left_g   = (run_sign == wcdg_pkg::SIGN_POS) ? grad_w :
                       ((run_sign == wcdg_pkg::SIGN_NEG) ? -grad_w : 64'sd0);
            right_g  = -left_g;
            weight_g = longint'(w.upstream_grad) * longint'(run_abs_diff);
            r.distance         = run_weighted;
            r.winner_index     = 10'(run_position);
            r.left_grad_part   = left_g[31:0];
            r.right_grad_part  = right_g[31:0];
            r.weight_grad_part = weight_g[31:0];
            pending_results.push_back(r);
            run_weighted = '0;
            run_abs_diff = '0;
            run_sign     = wcdg_pkg::SIGN_ZERO;
            run_weight   = '0;
            run_position = 0;
            run_count    = 0;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // sampled at the edge: the input handshake and the config write
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) model_min_mode = cfg_wdata;
            if (s_valid && s_ready) track_element(s_data);
        end
    end

    always @(posedge aclk) begin
        wcdg_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result word", m_data.distance, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.distance !== want.distance)
                    flag_mismatch("distance", m_data.distance, want.distance);
                if (m_data.winner_index !== want.winner_index)
                    flag_mismatch("winner_index", 32'(m_data.winner_index),
                                  32'(want.winner_index));
                if (m_data.left_grad_part !== want.left_grad_part)
                    flag_mismatch("left_grad_part", m_data.left_grad_part,
                                  want.left_grad_part);
                if (m_data.right_grad_part !== want.right_grad_part)
                    flag_mismatch("right_grad_part", m_data.right_grad_part,
                                  want.right_grad_part);
                if (m_data.weight_grad_part !== want.weight_grad_part)
                    flag_mismatch("weight_grad_part", m_data.weight_grad_part,
                                  want.weight_grad_part);
            end
        end
    end

    // receiver back-pressure: a new random stall pattern whenever the current one runs out
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ~m_ready;
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[weighted_chebyshev_distance_grad_core] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one element word, with a random gap at the start of each burst
    task automatic send_word(input wcdg_pkg::in_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        // words that give no result may still sit in the pipeline
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_min_mode(input logic mode);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_wdata <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic wcdg_pkg::in_word_t make_word(input int l, input int r, input int wt,
                                                     input int g, input bit last);
        wcdg_pkg::in_word_t w;
        w.left_elem     = 16'(l);
        w.right_elem    = 16'(r);
        w.weight_elem   = 16'(wt);
        w.upstream_grad = 16'(g);
        w.last_element  = last;
        return w;
    endfunction

    function automatic int edge_value();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return -1;
            2: return 0;
            3: return 1;
            default: return 32767;
        endcase
    endfunction

    function automatic wcdg_pkg::in_word_t random_word(input bit last);
        int l;
        int r;
        int wt;
        case ($urandom_range(0, 5))
            0: begin
                l = edge_value();
                r = edge_value();
            end
            1: begin
                l = $urandom_range(0, 65535) - 32768;
                r = l;
            end
            2: begin
                l = $urandom_range(0, 200) - 100;
                r = $urandom_range(0, 200) - 100;
            end
            default: begin
                l = $urandom_range(0, 65535) - 32768;
                r = $urandom_range(0, 65535) - 32768;
            end
        endcase
        case ($urandom_range(0, 7))
            0: wt = 0;
            1: wt = 65535;
            2: wt = $urandom_range(0, 15);
            default: wt = $urandom_range(0, 65535);
        endcase
        return make_word(l, r, wt, $urandom_range(0, 65535) - 32768, last);
    endfunction

    task automatic test_single_element_pairs();
        send_word(make_word(32767, -32768, 65535, -32768, 1));
        send_word(make_word(-32768, 32767, 65535, 32767, 1));
        send_word(make_word(100, 100, 500, 1234, 1));
        send_word(make_word(-5, 3, 0, -1, 1));
        send_word(make_word(0, 0, 0, 0, 1));
        send_word(make_word(32767, -32768, 65535, 32767, 1));
    endtask

    task automatic test_ties_keep_earlier();
        // three equal products, the first one stays
        send_word(make_word(10, 4, 2, 0, 0));
        send_word(make_word(1, -5, 2, 0, 0));
        send_word(make_word(3, 0, 4, 77, 1));
        // strict gain, then a tie with the opposite sign
        send_word(make_word(1, 0, 1, 0, 0));
        send_word(make_word(5, 0, 1, 0, 0));
        send_word(make_word(0, 5, 1, -300, 1));
    endtask

    task automatic test_min_mode();
        write_min_mode(1'b1);
        send_word(make_word(9, 0, 1, 0, 0));
        send_word(make_word(0, 3, 2, 0, 0));
        send_word(make_word(2, 0, 3, 0, 0));
        send_word(make_word(0, 0, 9, 0, 0));
        send_word(make_word(100, 0, 1, 555, 1));
        send_word(make_word(0, 0, 7, 0, 0));
        send_word(make_word(1, 0, 1, -9, 1));
    endtask

    task automatic test_mid_pair_mode_change();
        send_word(make_word(5, 0, 1, 0, 0));
        send_word(make_word(9, 0, 1, 0, 0));
        write_min_mode(1'b0);
        send_word(make_word(7, 0, 1, 0, 0));
        send_word(make_word(3, 0, 1, 1000, 1));
    endtask

    task automatic test_index_saturation();
        int i;
        write_min_mode(1'b0);
        for (i = 0; i < TOP_INDEX + 7; i++) begin
            if (i <= TOP_INDEX) begin
                send_word(make_word($urandom_range(0, 128) - 64, $urandom_range(0, 128) - 64,
                                    $urandom_range(0, 255), 0, 0));
            end else begin
                // growing products past the top index all land on it
                send_word(make_word(1000 + i, 0, 1000, $urandom_range(0, 65535) - 32768,
                                    i == TOP_INDEX + 6));
            end
        end
    endtask

    task automatic test_random_pairs();
        int       phase;
        int       sent;
        int       len;
        int       k;
        wcdg_pkg::in_word_t w;
        wcdg_pkg::in_word_t prev;
        prev = random_word(0);
        for (phase = 0; phase < 4; phase++) begin
            write_min_mode(phase[0]);
            sent = 0;
            while (sent < RANDOM_ITEMS / 4) begin
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(1, 40);
                    1, 2, 3, 4, 5: len = $urandom_range(7, 20);
                    default: len = $urandom_range(1, 6);
                endcase
                for (k = 0; k < len; k++) begin
                    // repeat the previous element now and then to force ties
                    if ($urandom_range(0, 7) == 0) begin
                        w = prev;
                        w.upstream_grad = 16'($urandom_range(0, 65535));
                    end else begin
                        w = random_word(0);
                    end
                    w.last_element = (k == len - 1);
                    send_word(w);
                    prev = w;
                end
                sent += len;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_single_element_pairs();
        test_ties_keep_earlier();
        test_min_mode();
        test_mid_pair_mode_change();
        test_index_saturation();
        test_random_pairs();
        wait_idle();
        if (error_count == 0) begin
            $display("[weighted_chebyshev_distance_grad_core] OK");
        end else begin
            $display("[weighted_chebyshev_distance_grad_core] ERROR");
        end
        $finish;
    end

endmodule
